// ===== hdl/trap_syndrome_decode_mmio_route_assert.svh =====
// Assertion macros for the trap syndrome decoder checker.
// Needs clk and rst_n in scope where a macro is used.
`ifndef TRAP_SYNDROME_DECODE_MMIO_ROUTE_ASSERT_SVH
`define TRAP_SYNDROME_DECODE_MMIO_ROUTE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSDMR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSDMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tsdmr_pkg.sv =====
// Shared types and constants for the trap syndrome decoder with MMIO routing.
// No dependencies.
package tsdmr_pkg;

    localparam int MAX_REGIONS = 8;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W      = 64;
    localparam int SYN_W       = 32;
    localparam int IDX_W       = 3;

    // Syndrome field positions
    localparam int SYN_EC_LSB  = 26;
    localparam int SYN_IL_BIT  = 25;
    localparam int SYN_ISV_BIT = 24;
    localparam int SYN_SAS_LSB = 22;
    localparam int SYN_SRT_LSB = 16;
    localparam int SYN_WNR_BIT = 6;

    // Exception class codes
    localparam logic [5:0] EC_DABT_LOWER = 6'h24;
    localparam logic [5:0] EC_DABT_SAME  = 6'h25;
    localparam logic [5:0] EC_HVC        = 6'h16;
    localparam logic [5:0] EC_SMC        = 6'h17;
    localparam logic [5:0] EC_SYSREG     = 6'h18;
    localparam logic [5:0] EC_WFI        = 6'h01;

    // Exit reasons
    localparam logic [2:0] EXIT_MMIO_READ  = 3'd0;
    localparam logic [2:0] EXIT_MMIO_WRITE = 3'd1;
    localparam logic [2:0] EXIT_HVC        = 3'd2;
    localparam logic [2:0] EXIT_SMC        = 3'd3;
    localparam logic [2:0] EXIT_SYSREG     = 3'd4;
    localparam logic [2:0] EXIT_WFI        = 3'd5;
    localparam logic [2:0] EXIT_FAULT      = 3'd6;
    localparam logic [2:0] EXIT_UNKNOWN    = 3'd7;

    localparam logic [2:0] PC_ADV_NONE = 3'd0;
    localparam logic [2:0] PC_ADV_WORD = 3'd4;
    localparam logic [2:0] LEN_HALF    = 3'd2;
    localparam logic [2:0] LEN_WORD    = 3'd4;

    // Lookup token walking the cell row
    typedef struct packed {
        logic              vld;
        logic              lookup;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] offset;
    } token_t;

    // Decoded syndrome fields
    typedef struct packed {
        logic [2:0] exit_reason;
        logic [2:0] instr_length;
        logic [4:0] target_reg;
        logic [3:0] access_bytes;
        logic [2:0] pc_advance;
        logic       lookup;
    } dec_t;

endpackage

// ===== hdl/tsdmr_decode.sv =====
// Syndrome field decode for trap commands; zero fields for register commands.
// Depends on tsdmr_pkg.
module tsdmr_decode
    import tsdmr_pkg::*;
(
    input  logic             cmd,
    input  logic [SYN_W-1:0] syndrome,
    output dec_t             dec
);

    logic [5:0] ec;
    logic [2:0] len;

    assign ec  = syndrome[SYN_EC_LSB +: 6];
    assign len = syndrome[SYN_IL_BIT] ? LEN_WORD : LEN_HALF;

    always_comb
    begin
        dec              = '0;
        dec.instr_length = len;
        case (ec) inside
            EC_DABT_LOWER, EC_DABT_SAME:
            begin
                if (!syndrome[SYN_ISV_BIT])
                begin
                    dec.exit_reason = EXIT_FAULT;
                end
                else
                begin
                    dec.exit_reason  = syndrome[SYN_WNR_BIT] ? EXIT_MMIO_WRITE
                                                             : EXIT_MMIO_READ;
                    dec.target_reg   = syndrome[SYN_SRT_LSB +: 5];
                    dec.access_bytes = 4'b0001 << syndrome[SYN_SAS_LSB +: 2];
                    dec.pc_advance   = len;
                    dec.lookup       = 1'b1;
                end
            end
            EC_HVC:
            begin
                dec.exit_reason = EXIT_HVC;
            end
            EC_SMC:
            begin
                dec.exit_reason = EXIT_SMC;
                dec.pc_advance  = PC_ADV_WORD;
            end
            EC_SYSREG:
            begin
                dec.exit_reason = EXIT_SYSREG;
                dec.pc_advance  = PC_ADV_WORD;
            end
            EC_WFI:
            begin
                dec.exit_reason = EXIT_WFI;
                dec.pc_advance  = PC_ADV_WORD;
            end
            default:
            begin
                dec.exit_reason = EXIT_UNKNOWN;
                dec.pc_advance  = PC_ADV_NONE;
            end
        endcase
        // Register command: drop every trap field
        if (cmd)
        begin
            dec = '0;
        end
    end

endmodule

// ===== hdl/tsdmr_cell.sv =====
// One region cell: holds a base and length, tests the passing token, hands it on.
// Depends on tsdmr_pkg.
module tsdmr_cell
    import tsdmr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  cell_id,
    input  logic              entry_valid,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_base,
    input  logic [ADDR_W-1:0] wr_length,
    input  token_t            tok_in,
    output token_t            tok_out
);

    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] length_reg;
    token_t            tok_reg;
    token_t            tok_next;
    logic [ADDR_W:0]   diff;
    logic              match;

    // Borrow out of the subtract means address below base
    assign diff  = {1'b0, tok_in.addr} - {1'b0, base_reg};
    assign match = entry_valid && tok_in.lookup && !tok_in.hit
                   && !diff[ADDR_W] && (diff[ADDR_W-1:0] < length_reg);

    always_comb
    begin
        tok_next = tok_in;
        if (match)
        begin
            tok_next.hit    = 1'b1;
            tok_next.idx    = cell_id;
            tok_next.offset = diff[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            base_reg   <= wr_base;
            length_reg <= wr_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== hdl/trap_syndrome_decode_mmio_route.sv =====
// Trap syndrome decoder with MMIO region routing, top level.
// Depends on tsdmr_pkg, tsdmr_decode and tsdmr_cell.
//
// Usage:
//   Raise start with cmd and the payload ports; the command word is taken at
//   the rising edge where start is high and busy is low. cmd = 1 appends
//   region_base/region_length to the region table (register_ok = 0 when the
//   table is full); cmd = 0 decodes syndrome and, for a data abort with a
//   valid syndrome, finds the first region holding fault_address.
//   Each command gives exactly one result word, shown for one cycle with
//   done high. The receiver cannot stall; the result ports hold until the
//   next command is taken.
// Flow:
//   The lookup token walks a row of MAX_REGIONS cells, one cell per cycle,
//   and done rises when it reaches the output of the last cell. busy stays
//   high until the done cycle ends, so a new command is taken only after
//   the previous result word. Register commands take the same path so
//   every result keeps the same latency.
// Reset:
//   rst_n clears the region count and the token row; table entries are not
//   cleared and are read only once registered.
module trap_syndrome_decode_mmio_route
    import tsdmr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cmd,
    input  logic [SYN_W-1:0]  syndrome,
    input  logic [ADDR_W-1:0] fault_address,
    input  logic [ADDR_W-1:0] region_base,
    input  logic [ADDR_W-1:0] region_length,
    output logic              done,
    output logic [2:0]        exit_reason,
    output logic [2:0]        instr_length,
    output logic [4:0]        target_reg,
    output logic [3:0]        access_bytes,
    output logic              region_hit,
    output logic [IDX_W-1:0]  region_index,
    output logic [ADDR_W-1:0] region_offset,
    output logic [2:0]        pc_advance,
    output logic              register_ok
);

    logic             accept;
    logic             not_full;
    dec_t             dec;
    dec_t             dec_reg;
    logic             ok_reg;
    logic             ok_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    token_t           head_reg;
    token_t           head_next;
    token_t           tok_chain [MAX_REGIONS+1];
    logic [MAX_REGIONS-1:0] cell_busy;

    assign accept   = start && !busy;
    assign not_full = (count_reg < CNT_W'(MAX_REGIONS));

    // Decode the syndrome straight off the input ports
    tsdmr_decode u_decode (
        .cmd      (cmd),
        .syndrome (syndrome),
        .dec      (dec)
    );

    // Launch the token on every accept; count a register command with room
    always_comb
    begin
        count_next = count_reg;
        ok_next    = ok_reg;
        head_next  = head_reg;
        head_next.vld = 1'b0;
        if (accept)
        begin
            ok_next = cmd && not_full;
            if (cmd && not_full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            head_next.vld    = 1'b1;
            head_next.lookup = dec.lookup;
            head_next.addr   = fault_address;
            head_next.hit    = 1'b0;
            head_next.idx    = '0;
            head_next.offset = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    // Hold the decoded fields for the whole walk
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dec_reg <= dec;
        end
        ok_reg <= ok_next;
    end

    assign tok_chain[0] = head_reg;

    // Row of region cells; cell i holds table entry i
    for (genvar i = 0; i < MAX_REGIONS; i++)
    begin : g_cell
        logic entry_valid;
        logic wr_en;

        assign entry_valid = (CNT_W'(i) < count_reg);
        assign wr_en       = accept && cmd && (count_reg == CNT_W'(i));

        tsdmr_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_id     (IDX_W'(i)),
            .entry_valid (entry_valid),
            .wr_en       (wr_en),
            .wr_base     (region_base),
            .wr_length   (region_length),
            .tok_in      (tok_chain[i]),
            .tok_out     (tok_chain[i+1])
        );

        assign cell_busy[i] = tok_chain[i+1].vld;
    end

    // Busy while the token is anywhere in the row, the done cycle included
    assign busy = head_reg.vld || (|cell_busy);

    assign done          = tok_chain[MAX_REGIONS].vld;
    assign exit_reason   = dec_reg.exit_reason;
    assign instr_length  = dec_reg.instr_length;
    assign target_reg    = dec_reg.target_reg;
    assign access_bytes  = dec_reg.access_bytes;
    assign pc_advance    = dec_reg.pc_advance;
    assign register_ok   = ok_reg;
    assign region_hit    = tok_chain[MAX_REGIONS].hit;
    assign region_index  = tok_chain[MAX_REGIONS].idx;
    assign region_offset = tok_chain[MAX_REGIONS].offset;

endmodule

// ===== hdl/tsdmr_checker.sv =====
// Port-level checker for the trap syndrome decoder, bound to the top level.
// Depends on tsdmr_pkg and trap_syndrome_decode_mmio_route_assert.svh.
`include "trap_syndrome_decode_mmio_route_assert.svh"

module tsdmr_checker
    import tsdmr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [2:0]        exit_reason,
    input logic [2:0]        instr_length,
    input logic              region_hit,
    input logic [2:0]        pc_advance,
    input logic              register_ok
);

    `TSDMR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "no hold after accept")
    `TSDMR_ASSERT_SAME(a_done_busy, done, busy, "result word outside busy window")
    `TSDMR_ASSERT_NEXT(a_done_frees, done, !busy && !done, "row not empty after result")
    `TSDMR_ASSERT_SAME(a_reg_clean, done && register_ok, exit_reason == EXIT_MMIO_READ && !region_hit && pc_advance == PC_ADV_NONE && instr_length == 3'd0, "register word carries trap fields")
    `TSDMR_ASSERT_SAME(a_hit_mmio, done && region_hit, (exit_reason == EXIT_MMIO_READ || exit_reason == EXIT_MMIO_WRITE) && !register_ok && pc_advance == instr_length, "hit on non-MMIO word")

endmodule

bind trap_syndrome_decode_mmio_route tsdmr_checker u_tsdmr_checker (.*);

// ===== test/tb_trap_syndrome_decode_mmio_route.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for trap_syndrome_decode_mmio_route: a directed table, then random
// command words, each checked against a behavioural decoder and table or a typed row.
// Depends on tsdmr_pkg and the trap_syndrome_decode_mmio_route RTL.
module tb_trap_syndrome_decode_mmio_route;
    import tsdmr_pkg::*;

    // Command codes on the cmd port
    localparam logic CMD_TRAP     = 1'b0;
    localparam logic CMD_REGISTER = 1'b1;

    localparam int RANDOM_WORDS   = 1625;
    localparam int DRAIN_EVERY    = 400;
    localparam int WATCHDOG_LIMIT = 1000;
    // Length of the idle tail that watches for a stray strobe at the end
    localparam int TAIL_CYCLES    = MAX_REGIONS + 6;

    typedef struct packed {
        logic              cmd;
        logic [SYN_W-1:0]  syndrome;
        logic [ADDR_W-1:0] fault_address;
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] region_length;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0]        exit_reason;
        logic [2:0]        instr_length;
        logic [4:0]        target_reg;
        logic [3:0]        access_bytes;
        logic              region_hit;
        logic [IDX_W-1:0]  region_index;
        logic [ADDR_W-1:0] region_offset;
        logic [2:0]        pc_advance;
        logic              register_ok;
    } exit_word_t;

    // One row of the directed table; 'typed' marks a hand-written expectation
    typedef struct packed {
        cmd_word_t  w;
        logic       typed;
        exit_word_t res;
    } script_row_t;

    localparam exit_word_t REG_ACCEPTED = '{register_ok: 1'b1, default: '0};
    // Doubleword read into x31, 4-byte instruction, nothing registered yet
    localparam exit_word_t EMPTY_TABLE_MISS = '{exit_reason: EXIT_MMIO_READ,
                                                instr_length: LEN_WORD,
                                                target_reg: 5'd31,
                                                access_bytes: 4'd8,
                                                pc_advance: PC_ADV_WORD,
                                                default: '0};

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              cmd;
    logic [SYN_W-1:0]  syndrome;
    logic [ADDR_W-1:0] fault_address;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] region_length;
    logic              done;
    logic [2:0]        exit_reason;
    logic [2:0]        instr_length;
    logic [4:0]        target_reg;
    logic [3:0]        access_bytes;
    logic              region_hit;
    logic [IDX_W-1:0]  region_index;
    logic [ADDR_W-1:0] region_offset;
    logic [2:0]        pc_advance;
    logic              register_ok;

    // Behavioural copy of the region table
    logic [ADDR_W-1:0] region_base_tab [MAX_REGIONS];
    logic [ADDR_W-1:0] region_len_tab  [MAX_REGIONS];
    int                regions_held;

    exit_word_t  exits_due[$];
    script_row_t script[$];
    int          mismatches;
    int          quiet_cycles;
    int          burst_left;

    trap_syndrome_decode_mmio_route DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .syndrome      (syndrome),
        .fault_address (fault_address),
        .region_base   (region_base),
        .region_length (region_length),
        .done          (done),
        .exit_reason   (exit_reason),
        .instr_length  (instr_length),
        .target_reg    (target_reg),
        .access_bytes  (access_bytes),
        .region_hit    (region_hit),
        .region_index  (region_index),
        .region_offset (region_offset),
        .pc_advance    (pc_advance),
        .register_ok   (register_ok)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Build a syndrome from its fields; unnamed bits stay zero
    function automatic logic [31:0] syn_of(logic [5:0] ec, logic il, logic isv,
                                           logic [1:0] sas, logic [4:0] srt, logic wnr);
        return {ec, il, isv, sas, 1'b0, srt, 9'b0, wnr, 6'b0};
    endfunction

    function automatic cmd_word_t trap_word(logic [31:0] syn, logic [63:0] addr);
        cmd_word_t w;
        // Region ports are ignored on a trap; toggle them anyway
        w.cmd           = CMD_TRAP;
        w.syndrome      = syn;
        w.fault_address = addr;
        w.region_base   = rand64();
        w.region_length = rand64();
        return w;
    endfunction

    function automatic cmd_word_t register_word(logic [63:0] base, logic [63:0] len);
        cmd_word_t w;
        w.cmd           = CMD_REGISTER;
        w.syndrome      = $urandom;
        w.fault_address = rand64();
        w.region_base   = base;
        w.region_length = len;
        return w;
    endfunction

    function automatic exit_word_t no_advance(logic [2:0] reason, logic [2:0] len);
        exit_word_t r;
        r              = '0;
        r.exit_reason  = reason;
        r.instr_length = len;
        return r;
    endfunction

    // Predict the exit word of one command and update the region table.
    // The range test is base <= addr and addr - base < len, so a region
    // running past the top of the address space is not wrapped, and a
    // zero-length region never matches.
    function automatic exit_word_t route_command(cmd_word_t w);
        exit_word_t r;
        logic [5:0] ec;
        r = '0;
        if (w.cmd == CMD_REGISTER)
        begin
            if (regions_held < MAX_REGIONS)
            begin
                region_base_tab[regions_held] = w.region_base;
                region_len_tab[regions_held]  = w.region_length;
                regions_held++;
                r.register_ok = 1'b1;
            end
            return r;
        end
        ec             = w.syndrome[SYN_EC_LSB +: 6];
        r.instr_length = w.syndrome[SYN_IL_BIT] ? LEN_WORD : LEN_HALF;
        case (ec)
            EC_DABT_LOWER, EC_DABT_SAME:
            begin
                if (!w.syndrome[SYN_ISV_BIT])
                    r.exit_reason = EXIT_FAULT;
                else
                begin
                    r.exit_reason  = w.syndrome[SYN_WNR_BIT] ? EXIT_MMIO_WRITE : EXIT_MMIO_READ;
                    r.target_reg   = w.syndrome[SYN_SRT_LSB +: 5];
                    r.access_bytes = 4'd1 << w.syndrome[SYN_SAS_LSB +: 2];
                    r.pc_advance   = r.instr_length;
                    for (int i = 0; i < regions_held; i++)
                    begin
                        if (!r.region_hit && w.fault_address >= region_base_tab[i] &&
                            (w.fault_address - region_base_tab[i]) < region_len_tab[i])
                        begin
                            r.region_hit    = 1'b1;
                            r.region_index  = i[IDX_W-1:0];
                            r.region_offset = w.fault_address - region_base_tab[i];
                        end
                    end
                end
            end
            EC_HVC:    r.exit_reason = EXIT_HVC;
            EC_SMC:
            begin
                r.exit_reason = EXIT_SMC;
                r.pc_advance  = PC_ADV_WORD;
            end
            EC_SYSREG:
            begin
                r.exit_reason = EXIT_SYSREG;
                r.pc_advance  = PC_ADV_WORD;
            end
            EC_WFI:
            begin
                r.exit_reason = EXIT_WFI;
                r.pc_advance  = PC_ADV_WORD;
            end
            default:   r.exit_reason = EXIT_UNKNOWN;
        endcase
        return r;
    endfunction

    // Pick a lookup address: mostly on or just around the edges of a known region
    function automatic logic [63:0] aim_address();
        int          pick;
        logic [63:0] b;
        logic [63:0] l;
        if (regions_held == 0 || $urandom_range(0, 9) == 0)
            return rand64();
        pick = $urandom_range(0, regions_held - 1);
        b    = region_base_tab[pick];
        l    = region_len_tab[pick];
        case ($urandom_range(0, 5))
            0:       return b;
            1:       return b + l - 64'd1;
            2:       return b + l;
            3:       return b - 64'd1;
            default: return (l == 64'd0) ? b : b + (rand64() % l);
        endcase
    endfunction

    function automatic cmd_word_t random_word();
        logic [31:0] syn;
        logic [63:0] base;
        int          pick;
        pick = $urandom_range(0, 99);
        syn  = $urandom;
        // Rare register words: the first few fill the table, the rest find it full
        if (pick < 3)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    // overlap an existing region so first-match order matters
                    base = (regions_held == 0) ? rand64() :
                           region_base_tab[$urandom_range(0, regions_held - 1)] +
                           64'($urandom_range(0, 255));
                    return register_word(base, 64'($urandom_range(1, 4096)));
                end
                1: return register_word(rand64() | 64'hFFFF_FFFF_FFFF_0000,
                                        64'($urandom_range(32'h1000, 32'h2_0000)));
                2: return register_word(rand64(), 64'd0);
                3: return register_word(rand64(), rand64());
                default: return register_word(rand64(), 64'($urandom_range(1, 65535)));
            endcase
        end
        if (pick < 58)
        begin
            syn[SYN_EC_LSB +: 6] = $urandom_range(0, 1) ? EC_DABT_LOWER : EC_DABT_SAME;
            syn[SYN_ISV_BIT]     = 1'b1;
            return trap_word(syn, aim_address());
        end
        if (pick < 68)
        begin
            syn[SYN_EC_LSB +: 6] = $urandom_range(0, 1) ? EC_DABT_LOWER : EC_DABT_SAME;
            syn[SYN_ISV_BIT]     = 1'b0;
            return trap_word(syn, aim_address());
        end
        if (pick < 88)
        begin
            case ($urandom_range(0, 3))
                0:       syn[SYN_EC_LSB +: 6] = EC_HVC;
                1:       syn[SYN_EC_LSB +: 6] = EC_SMC;
                2:       syn[SYN_EC_LSB +: 6] = EC_SYSREG;
                default: syn[SYN_EC_LSB +: 6] = EC_WFI;
            endcase
            return trap_word(syn, aim_address());
        end
        // Raw syndrome: mostly classes the block does not know
        return trap_word(syn, rand64());
    endfunction

    // Present one command word and hold it until accepted, then log its expectation
    task automatic send_word(input cmd_word_t w, input logic typed, input exit_word_t typed_res);
        exit_word_t predicted;
        start         <= 1'b1;
        cmd           <= w.cmd;
        syndrome      <= w.syndrome;
        fault_address <= w.fault_address;
        region_base   <= w.region_base;
        region_length <= w.region_length;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predicted = route_command(w);
        exits_due.push_back(typed ? typed_res : predicted);
    endtask

    // Sender pacing: bursts of random length, random gaps between them,
    // and now and then a long stretch with no idling at all
    task automatic pace();
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(0, 4) == 0 ? $urandom_range(14, 40) : $urandom_range(1, 13))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // Hold off the sender until every outstanding exit word has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (exits_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: take each done word and compare it with the oldest expectation.
    // Sample at the rising edge, so the values seen are those of the cycle ending.
    always @(posedge clk)
    begin
        exit_word_t want;
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
            begin
                if (exits_due.size() == 0)
                begin
                    $error("exit word arrived with nothing outstanding");
                    mismatches++;
                end
                else
                begin
                    want = exits_due.pop_front();
                    check_field("exit_reason", 64'(want.exit_reason), 64'(exit_reason));
                    check_field("instr_length", 64'(want.instr_length), 64'(instr_length));
                    check_field("target_reg", 64'(want.target_reg), 64'(target_reg));
                    check_field("access_bytes", 64'(want.access_bytes), 64'(access_bytes));
                    check_field("region_hit", 64'(want.region_hit), 64'(region_hit));
                    check_field("region_index", 64'(want.region_index), 64'(region_index));
                    check_field("region_offset", want.region_offset, region_offset);
                    check_field("pc_advance", 64'(want.pc_advance), 64'(pc_advance));
                    check_field("register_ok", 64'(want.register_ok), 64'(register_ok));
                end
            end
            // Watchdog: any accepted command or returned word counts as progress
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_trap_syndrome_decode_mmio_route: errors");
                $finish;
            end
        end
    end

    initial
    begin
        // Initialise every input before the first edge
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = CMD_TRAP;
        syndrome      = '0;
        fault_address = '0;
        region_base   = '0;
        region_length = '0;
        mismatches    = 0;
        quiet_cycles  = 0;
        burst_left    = 0;
        regions_held  = 0;
        for (int i = 0; i < MAX_REGIONS; i++)
        begin
            region_base_tab[i] = '0;
            region_len_tab[i]  = '0;
        end

        // Directed table. Rows with a typed expectation are the all-zero and
        // all-ones syndromes, a lookup into the empty table, the register
        // acknowledgements and data aborts without a valid syndrome.
        script.push_back('{trap_word(32'h0, 64'h0), 1'b1,
                           no_advance(EXIT_UNKNOWN, LEN_HALF)});
        script.push_back('{trap_word(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF), 1'b1,
                           no_advance(EXIT_UNKNOWN, LEN_WORD)});
        script.push_back('{trap_word(syn_of(EC_DABT_LOWER, 1'b1, 1'b1, 2'd3, 5'd31, 1'b0),
                                     64'h1000), 1'b1, EMPTY_TABLE_MISS});
        // Region 1 overlaps region 0, region 2 is empty, region 3 runs past the top
        script.push_back('{register_word(64'h1000, 64'h100), 1'b1, REG_ACCEPTED});
        script.push_back('{register_word(64'h1080, 64'h100), 1'b1, REG_ACCEPTED});
        script.push_back('{register_word(64'h2000, 64'h0), 1'b1, REG_ACCEPTED});
        script.push_back('{register_word(64'hFFFF_FFFF_FFFF_F000, 64'h2000), 1'b1,
                           REG_ACCEPTED});
        script.push_back('{trap_word(syn_of(EC_DABT_SAME, 1'b0, 1'b1, 2'd0, 5'd0, 1'b1),
                                     64'h1000), 1'b0, '0});
        script.push_back('{trap_word(syn_of(EC_DABT_LOWER, 1'b1, 1'b1, 2'd1, 5'd5, 1'b0),
                                     64'h10FF), 1'b0, '0});
        script.push_back('{trap_word(syn_of(EC_DABT_SAME, 1'b1, 1'b1, 2'd2, 5'd17, 1'b1),
                                     64'h1100), 1'b0, '0});
        script.push_back('{trap_word(syn_of(EC_DABT_LOWER, 1'b1, 1'b1, 2'd3, 5'd30, 1'b0),
                                     64'h117F), 1'b0, '0});
        script.push_back('{trap_word(syn_of(EC_DABT_LOWER, 1'b0, 1'b1, 2'd2, 5'd9, 1'b0),
                                     64'h1180), 1'b0, '0});
        script.push_back('{trap_word(syn_of(EC_DABT_SAME, 1'b1, 1'b1, 2'd1, 5'd12, 1'b1),
                                     64'h2000), 1'b0, '0});
        script.push_back('{trap_word(syn_of(EC_DABT_SAME, 1'b1, 1'b1, 2'd3, 5'd1, 1'b0),
                                     64'hFFFF_FFFF_FFFF_FFFF), 1'b0, '0});
        script.push_back('{trap_word(syn_of(EC_DABT_LOWER, 1'b1, 1'b1, 2'd0, 5'd2, 1'b1),
                                     64'h0FFF), 1'b0, '0});
        script.push_back('{trap_word(syn_of(EC_DABT_LOWER, 1'b0, 1'b1, 2'd1, 5'd3, 1'b0),
                                     64'hFFFF_FFFF_FFFF_EFFF), 1'b0, '0});
        script.push_back('{trap_word(syn_of(EC_DABT_LOWER, 1'b1, 1'b0, 2'd3, 5'd31, 1'b1),
                                     64'h1000), 1'b1, no_advance(EXIT_FAULT, LEN_WORD)});
        script.push_back('{trap_word(syn_of(EC_DABT_SAME, 1'b0, 1'b0, 2'd2, 5'd7, 1'b0),
                                     64'h1080), 1'b1, no_advance(EXIT_FAULT, LEN_HALF)});
        script.push_back('{trap_word(syn_of(EC_HVC, 1'b1, 1'b0, 2'd0, 5'd0, 1'b0), 64'h0),
                           1'b0, '0});
        script.push_back('{trap_word(syn_of(EC_SMC, 1'b0, 1'b0, 2'd0, 5'd0, 1'b0), 64'h0),
                           1'b0, '0});
        script.push_back('{trap_word(syn_of(EC_SYSREG, 1'b1, 1'b1, 2'd3, 5'd4, 1'b1),
                                     64'h1000), 1'b0, '0});
        script.push_back('{trap_word(syn_of(EC_WFI, 1'b0, 1'b1, 2'd1, 5'd8, 1'b0), 64'h1000),
                           1'b0, '0});
        // Non-MMIO class with every other bit set and a hitting address
        script.push_back('{trap_word({EC_HVC, 26'h3FF_FFFF}, 64'h1000), 1'b0, '0});
        // Class right next to the data abort codes
        script.push_back('{trap_word(syn_of(6'h26, 1'b1, 1'b1, 2'd3, 5'd31, 1'b1), 64'h1000),
                           1'b0, '0});
        script.push_back('{trap_word({EC_DABT_SAME, 26'h3FF_FFFF}, 64'h1010), 1'b0, '0});

        // Hold reset low, then release it on an edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            pace();
            send_word(script[i].w, script[i].typed, script[i].res);
        end
        drain();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n != 0 && n % DRAIN_EVERY == 0)
                drain();
            pace();
            send_word(random_word(), 1'b0, '0);
        end

        // Wait out every outstanding word, then a tail for any stray strobe
        start <= 1'b0;
        while (exits_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_trap_syndrome_decode_mmio_route: clean");
        else
            $display("tb_trap_syndrome_decode_mmio_route: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tsdmr_pkg.sv
hdl/tsdmr_decode.sv
hdl/tsdmr_cell.sv
hdl/trap_syndrome_decode_mmio_route.sv
hdl/tsdmr_checker.sv
test/tb_trap_syndrome_decode_mmio_route.sv
